// ----- src/bblc_pkg.sv -----
// Shared types and constants for the byte budget LRU cache.
`default_nettype none
package bblc_pkg;
  localparam int unsigned KeyW    = 32;
  localparam int unsigned SizeW   = 32;
  localparam int unsigned BudgetW = 40;
  localparam int unsigned UsedW   = 41;
  localparam logic [BudgetW-1:0] BudgetReset = 40'd536870912;

  typedef enum logic [1:0] {
    KIND_EVICT  = 2'd0,
    KIND_HIT    = 2'd1,
    KIND_INSERT = 2'd2,
    KIND_TRIM   = 2'd3
  } kind_e;

  typedef enum logic {
    OP_ACCESS = 1'b0,
    OP_TRIM   = 1'b1
  } op_e;

  localparam logic [0:0] RegByteBudget = 1'b0;

  typedef struct packed {
    logic             trim;
    logic [KeyW-1:0]  key;
    logic [SizeW-1:0] item_bytes;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_EVICT,
    ST_INSERT,
    ST_DONE
  } state_e;
endpackage
`default_nettype wire

// ----- src/bblc_if.sv -----
// Valid/ready channel interfaces for requests and results.
`default_nettype none
interface bblc_req_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [31:0] key;
  logic [31:0] item_bytes;
  modport source (output valid, operation, key, item_bytes, input ready);
  modport sink   (input valid, operation, key, item_bytes, output ready);
endinterface

interface bblc_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] result_key;
  logic [31:0] result_bytes;
  logic [40:0] used_after;
  logic        last;
  modport source (output valid, kind, result_key, result_bytes, used_after, last,
                  input ready);
  modport sink   (input valid, kind, result_key, result_bytes, used_after, last,
                  output ready);
endinterface
`default_nettype wire

// ----- src/byte_budget_lru_cache_top.sv -----
// Top level: APB budget register, request front end and directory back end.
//  channel | dir | handshake   | payload
//  req     | in  | valid/ready | operation, key, item_bytes
//  res     | out | valid/ready | kind, result_key, result_bytes, used_after, last
//  apb     | in  | psel/penable| byte_budget at address 0
// The directory scan walks one slot per cycle; a hit needs one scan, and a miss
// adds a further scan for each eviction plus an insert step.
// Reset empties the directory and sets the budget to 512 MiB.
// A stalled result holds the sequencer; the front queue keeps taking requests until it is full.
`default_nettype none
module byte_budget_lru_cache_top import bblc_pkg::*; #(
  parameter int unsigned ENTRIES = 16
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  bblc_req_if.sink    req,
  bblc_res_if.source  res,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [2:0]  paddr,
  input  wire  [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  logic [BudgetW-1:0] budget_q;
  cmd_t cmd;
  logic cmd_valid, cmd_pop;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegByteBudget) ? {24'd0, budget_q} : 64'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      budget_q <= BudgetReset;
    end else if (psel && penable && pwrite && paddr[2] == RegByteBudget &&
                 pwdata[BudgetW-1:0] != '0) begin
      budget_q <= pwdata[BudgetW-1:0];
    end
  end

  bblc_front u_front (
    .clk_i, .rst_ni, .req,
    .cmd_o(cmd), .cmd_valid_o(cmd_valid), .cmd_pop_i(cmd_pop)
  );

  bblc_back #(.ENTRIES(ENTRIES)) u_back (
    .clk_i, .rst_ni, .cmd_i(cmd), .cmd_valid_i(cmd_valid), .cmd_pop_o(cmd_pop),
    .budget_i(budget_q), .res
  );
endmodule
`default_nettype wire

// ----- src/bblc_front.sv -----
// Front end: accepts requests into a two-deep command queue.
`default_nettype none
module bblc_front import bblc_pkg::*; (
  input  wire         clk_i,
  input  wire         rst_ni,
  bblc_req_if.sink    req,
  output cmd_t        cmd_o,
  output logic        cmd_valid_o,
  input  wire         cmd_pop_i
);
  cmd_t       fifo_q [2];
  logic       rd_q, wr_q;
  logic [1:0] cnt_q;
  logic       push;

  assign req.ready   = (cnt_q != 2'd2);
  assign push        = req.valid && req.ready;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = fifo_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_q] <= '{trim: req.operation, key: req.key, item_bytes: req.item_bytes};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= 1'b0;
      wr_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (cmd_pop_i && cmd_valid_o) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, cmd_pop_i && cmd_valid_o};
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q != 2'd3)
    else $error("queue count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2 && !cmd_pop_i) |=> cnt_q == 2'd2)
    else $error("full queue lost an entry");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_i |-> cmd_valid_o)
    else $error("pop from empty queue");
endmodule
`default_nettype wire

// ----- src/bblc_back.sv -----
// Back end: directory scan, eviction sequencer and result register.
`default_nettype none
module bblc_back import bblc_pkg::*; #(
  parameter int unsigned ENTRIES = 16
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  cmd_t              cmd_i,
  input  wire               cmd_valid_i,
  output logic              cmd_pop_o,
  input  wire [BudgetW-1:0] budget_i,
  bblc_res_if.source        res
);
  localparam int unsigned IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CntW = $clog2(ENTRIES + 1);

  logic [KeyW-1:0]  keys_q  [ENTRIES];
  logic [SizeW-1:0] sizes_q [ENTRIES];
  logic [ENTRIES-1:0] valid_q;
  logic [IdxW-1:0]  rank_q  [ENTRIES];
  logic [UsedW-1:0] used_q;
  logic [CntW-1:0]  count_q;

  state_e state_q, state_d;
  logic [IdxW-1:0] ptr_q;
  logic            hit_q;
  logic [IdxW-1:0] hit_idx_q, victim_q, free_q;
  logic            free_found_q;

  logic             out_valid_q;
  logic [1:0]       out_kind_q;
  logic [KeyW-1:0]  out_key_q;
  logic [SizeW-1:0] out_bytes_q;
  logic [UsedW-1:0] out_used_q;
  logic             out_last_q;

  logic out_free, last_ptr, need_evict, match_now, oldest_now;
  logic [UsedW-1:0] need_bytes;

  assign out_free = !out_valid_q || res.ready;
  assign last_ptr = (ptr_q == IdxW'(ENTRIES - 1));
  assign need_bytes = cmd_i.trim ? used_q : used_q + UsedW'(cmd_i.item_bytes);
  assign need_evict = (count_q != '0) &&
                      ((need_bytes > UsedW'(budget_i)) ||
                       (!cmd_i.trim && count_q == CntW'(ENTRIES)));
  assign match_now  = valid_q[ptr_q] && keys_q[ptr_q] == cmd_i.key;
  assign oldest_now = valid_q[ptr_q] && rank_q[ptr_q] == IdxW'(count_q - 1'b1);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (cmd_valid_i) state_d = ST_SCAN;
      ST_SCAN:   if (last_ptr) state_d = ST_DECIDE;
      ST_DECIDE: begin
        if (!cmd_i.trim && hit_q) state_d = ST_DONE;
        else if (need_evict) state_d = ST_EVICT;
        else if (cmd_i.trim) state_d = ST_DONE;
        else state_d = ST_INSERT;
      end
      ST_EVICT:  if (out_free) state_d = ST_SCAN;
      ST_INSERT: state_d = ST_DONE;
      ST_DONE:   if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    cmd_pop_o = (state_q == ST_DONE) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      valid_q      <= '0;
      used_q       <= '0;
      count_q      <= '0;
      ptr_q        <= '0;
      hit_q        <= 1'b0;
      free_found_q <= 1'b0;
      out_valid_q  <= 1'b0;
      for (int i = 0; i < ENTRIES; i++) rank_q[i] <= '0;
    end else begin
      state_q <= state_d;
      if (out_valid_q && res.ready) out_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          ptr_q        <= '0;
          hit_q        <= 1'b0;
          free_found_q <= 1'b0;
        end
        ST_SCAN: begin
          // Walk one slot per cycle: match, oldest and first free slot.
          if (match_now) begin
            hit_q     <= 1'b1;
            hit_idx_q <= ptr_q;
          end
          if (oldest_now) victim_q <= ptr_q;
          if (!valid_q[ptr_q] && !free_found_q) begin
            free_found_q <= 1'b1;
            free_q       <= ptr_q;
          end
          ptr_q <= last_ptr ? '0 : ptr_q + 1'b1;
        end
        ST_DECIDE: begin
          hit_q        <= hit_q;
          free_found_q <= 1'b0;
          ptr_q        <= '0;
        end
        ST_EVICT: if (out_free) begin
          valid_q[victim_q] <= 1'b0;
          rank_q[victim_q]  <= '0;
          used_q  <= used_q - UsedW'(sizes_q[victim_q]);
          count_q <= count_q - 1'b1;
          hit_q   <= 1'b0;
          out_valid_q <= 1'b1;
          out_kind_q  <= KIND_EVICT;
          out_key_q   <= keys_q[victim_q];
          out_bytes_q <= sizes_q[victim_q];
          out_used_q  <= used_q - UsedW'(sizes_q[victim_q]);
          out_last_q  <= 1'b0;
        end
        ST_INSERT: begin
          for (int j = 0; j < ENTRIES; j++)
            if (valid_q[j]) rank_q[j] <= rank_q[j] + 1'b1;
          valid_q[free_q] <= 1'b1;
          rank_q[free_q]  <= '0;
          used_q  <= used_q + UsedW'(cmd_i.item_bytes);
          count_q <= count_q + 1'b1;
        end
        ST_DONE: if (out_free) begin
          out_valid_q <= 1'b1;
          out_last_q  <= 1'b1;
          out_used_q  <= used_q;
          if (cmd_i.trim) begin
            out_kind_q  <= KIND_TRIM;
            out_key_q   <= '0;
            out_bytes_q <= '0;
          end else if (hit_q) begin
            for (int j = 0; j < ENTRIES; j++)
              if (valid_q[j] && rank_q[j] < rank_q[hit_idx_q]) rank_q[j] <= rank_q[j] + 1'b1;
            rank_q[hit_idx_q] <= '0;
            out_kind_q  <= KIND_HIT;
            out_key_q   <= cmd_i.key;
            out_bytes_q <= sizes_q[hit_idx_q];
          end else begin
            out_kind_q  <= KIND_INSERT;
            out_key_q   <= cmd_i.key;
            out_bytes_q <= cmd_i.item_bytes;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_INSERT) begin
      keys_q[free_q]  <= cmd_i.key;
      sizes_q[free_q] <= cmd_i.item_bytes;
    end
  end

  assign res.valid        = out_valid_q;
  assign res.kind         = out_kind_q;
  assign res.result_key   = out_key_q;
  assign res.result_bytes = out_bytes_q;
  assign res.used_after   = out_used_q;
  assign res.last         = out_last_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == CntW'($countones(valid_q)))
    else $error("fill count disagrees with valid bits");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_INSERT |-> !valid_q[free_q])
    else $error("insert into occupied slot");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EVICT |-> valid_q[victim_q])
    else $error("evicting an empty slot");
endmodule
`default_nettype wire

// ----- tb/bblc_checker.sv -----
// Checker: predicts cache results from accepted requests and compares them.
`timescale 1ns / 100ps
`default_nettype none
module bblc_checker import bblc_pkg::*; #(
  parameter int unsigned ENTRIES = 16
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  bblc_req_if          req,
  bblc_res_if          res,
  input  wire          psel,
  input  wire          penable,
  input  wire          pwrite,
  input  wire   [2:0]  paddr,
  input  wire   [63:0] pwdata,
  input  wire          pready,
  output int           errors_o,
  output int           pending_o
);
  localparam logic [2:0] BudgetAddr = 3'(RegByteBudget) * 3'd0;

  typedef struct packed {
    kind_e             kind;
    logic [KeyW-1:0]   key;
    logic [SizeW-1:0]  bytes;
    logic [UsedW-1:0]  used;
    logic              last;
  } outcome_t;

  outcome_t             outcome_q[$];
  logic [KeyW-1:0]      slot_key  [ENTRIES];
  logic [SizeW-1:0]     slot_size [ENTRIES];
  logic                 slot_valid[ENTRIES];
  int unsigned          slot_age  [ENTRIES];
  logic [UsedW-1:0]     used_bytes;
  logic [BudgetW-1:0]   budget;
  int                   errors;

  task automatic report(input string what, input outcome_t got, input outcome_t want);
    $display({"%0t: %s: got kind=%0d key=%h bytes=%h used=%h last=%0d,",
              " want kind=%0d key=%h bytes=%h used=%h last=%0d"},
             $time, what, got.kind, got.key, got.bytes, got.used, got.last,
             want.kind, want.key, want.bytes, want.used, want.last);
    errors++;
  endtask

  function automatic int unsigned live_count();
    int unsigned n;
    n = 0;
    for (int i = 0; i < ENTRIES; i++) if (slot_valid[i]) n++;
    return n;
  endfunction

  function automatic outcome_t mk(kind_e k, logic [KeyW-1:0] key, logic [SizeW-1:0] b,
                                  logic last);
    outcome_t o;
    o.kind = k; o.key = key; o.bytes = b; o.used = used_bytes; o.last = last;
    return o;
  endfunction

  // Drop the oldest live entry and record the eviction.
  task automatic evict_oldest();
    int victim;
    victim = -1;
    for (int i = 0; i < ENTRIES; i++)
      if (slot_valid[i] && (victim < 0 || slot_age[i] > slot_age[victim])) victim = i;
    if (victim >= 0) begin
      slot_valid[victim] = 1'b0;
      slot_age[victim]   = 0;
      used_bytes = used_bytes - UsedW'(slot_size[victim]);
      outcome_q.push_back(mk(KIND_EVICT, slot_key[victim], slot_size[victim], 1'b0));
    end
  endtask

  task automatic predict_request(input logic trim, input logic [KeyW-1:0] key,
                                 input logic [SizeW-1:0] size);
    int hit_slot;
    int slot;
    hit_slot = -1;
    slot = -1;
    if (trim) begin
      while (live_count() > 0 && {1'b0, used_bytes} > {2'b0, budget}) evict_oldest();
      outcome_q.push_back(mk(KIND_TRIM, '0, '0, 1'b1));
      return;
    end
    for (int i = 0; i < ENTRIES; i++)
      if (hit_slot < 0 && slot_valid[i] && slot_key[i] == key) hit_slot = i;
    if (hit_slot >= 0) begin
      for (int j = 0; j < ENTRIES; j++)
        if (slot_valid[j] && slot_age[j] < slot_age[hit_slot]) slot_age[j]++;
      slot_age[hit_slot] = 0;
      outcome_q.push_back(mk(KIND_HIT, key, slot_size[hit_slot], 1'b1));
      return;
    end
    while (live_count() > 0 && ({1'b0, used_bytes} + 42'(size)) > {2'b0, budget})
      evict_oldest();
    if (live_count() >= ENTRIES) evict_oldest();
    for (int i = 0; i < ENTRIES; i++) if (slot < 0 && !slot_valid[i]) slot = i;
    for (int j = 0; j < ENTRIES; j++) if (slot_valid[j]) slot_age[j]++;
    slot_valid[slot] = 1'b1;
    slot_key[slot]   = key;
    slot_size[slot]  = size;
    slot_age[slot]   = 0;
    used_bytes = used_bytes + UsedW'(size);
    outcome_q.push_back(mk(KIND_INSERT, key, size, 1'b1));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t got;
    outcome_t want;
    if (!rst_ni) begin
      outcome_q.delete();
      for (int i = 0; i < ENTRIES; i++) begin
        slot_valid[i] = 1'b0;
        slot_age[i]   = 0;
      end
      used_bytes = '0;
      budget     = BudgetReset;
      errors     = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == BudgetAddr &&
          pwdata[BudgetW-1:0] != '0)
        budget = pwdata[BudgetW-1:0];
      if (res.valid && res.ready) begin
        got.kind  = kind_e'(res.kind);
        got.key   = res.result_key;
        got.bytes = res.result_bytes;
        got.used  = res.used_after;
        got.last  = res.last;
        if (outcome_q.size() == 0) begin
          report("unexpected result", got, got);
        end else begin
          want = outcome_q.pop_front();
          if (got.kind !== want.kind || got.key !== want.key || got.bytes !== want.bytes ||
              got.used !== want.used || got.last !== want.last)
            report("result mismatch", got, want);
        end
      end
      if (req.valid && req.ready)
        predict_request(req.operation, req.key, req.item_bytes);
    end
    errors_o  = errors;
    pending_o = outcome_q.size();
  end
endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
// Testbench top: clock, reset, request and budget stimulus, final verdict.
`timescale 1ns / 100ps
`default_nettype none
module testbench;
  import bblc_pkg::*;

  localparam int unsigned ENTRIES   = 16;
  localparam int unsigned CycleCap  = 2000000;
  localparam int unsigned LongHold  = 400;

  logic        clk;
  logic        rst_n;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;
  int          errors;
  int          pending;
  logic        calm;       // no idling on either side
  logic        hold_req;   // ask the receiver for one long stall
  int unsigned cycles;
  logic [31:0] key_pool[24];

  bblc_req_if req_ch();
  bblc_res_if res_ch();

  byte_budget_lru_cache_top #(.ENTRIES(ENTRIES)) u_top (
    .clk_i(clk), .rst_ni(rst_n), .req(req_ch), .res(res_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  bblc_checker #(.ENTRIES(ENTRIES)) u_checker (
    .clk_i(clk), .rst_ni(rst_n), .req(req_ch), .res(res_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready), .errors_o(errors), .pending_o(pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleCap) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Result side: random stalls, plus one long hold on request.
  initial begin
    res_ch.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        res_ch.ready <= 1'b0;
        repeat (LongHold) @(posedge clk);
        hold_req <= 1'b0;
        res_ch.ready <= 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
        res_ch.ready <= 1'b1;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_request(input op_e op, input logic [31:0] key, input logic [31:0] size);
    req_ch.valid      <= 1'b1;
    req_ch.operation  <= op;
    req_ch.key        <= key;
    req_ch.item_bytes <= size;
    @(negedge clk);
    while (!req_ch.ready) @(negedge clk);
    @(posedge clk);
    if (!calm && $urandom_range(0, 5) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0 || hold_req) @(negedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_budget(input logic [39:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(RegByteBudget) * 3'd0;
    pwdata  <= {24'h0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly keys from a small pool so hits and refreshes happen.
  task automatic random_requests(input int count, input logic [31:0] size_cap);
    op_e         op;
    logic [31:0] key;
    logic [31:0] size;
    for (int n = 0; n < count; n++) begin
      op   = ($urandom_range(0, 9) == 0) ? OP_TRIM : OP_ACCESS;
      key  = ($urandom_range(0, 4) == 0) ? $urandom() : key_pool[$urandom_range(0, 23)];
      size = ($urandom_range(0, 19) == 0) ? $urandom() : $urandom_range(0, size_cap);
      send_request(op, key, size);
    end
  endtask

  initial begin
    rst_n             = 1'b0;
    calm              = 1'b0;
    hold_req          = 1'b0;
    cycles            = 0;
    req_ch.valid      <= 1'b0;
    req_ch.operation  <= OP_ACCESS;
    req_ch.key        <= '0;
    req_ch.item_bytes <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    for (int i = 0; i < 24; i++) key_pool[i] = (i < 12) ? 32'(i) : $urandom();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, oversized item, trim, hit, full table.
    send_request(OP_ACCESS, 32'h0, 32'h0);
    send_request(OP_ACCESS, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(OP_TRIM, 32'hDEAD_BEEF, 32'h1234_5678);
    send_request(OP_ACCESS, 32'd5, 32'd100);
    send_request(OP_ACCESS, 32'd5, 32'd7);
    for (int i = 0; i < 17; i++) send_request(OP_ACCESS, 32'h100 + 32'(i), 32'd1);
    send_request(OP_ACCESS, 32'h100, 32'd9);
    send_request(OP_TRIM, 32'h0, 32'h0);
    drain();

    write_budget(40'h0);
    random_requests(60, 32'h0800_0000);
    drain();

    write_budget(40'd1000);
    send_request(OP_TRIM, 32'h0, 32'h0);
    hold_req <= 1'b1;
    random_requests(90, 32'd300);
    drain();

    write_budget(40'd1);
    random_requests(50, 32'd2);
    drain();

    write_budget(40'hFF_FFFF_FFFF);
    random_requests(70, 32'hFFFF_FFFF);
    drain();

    write_budget({8'h0, $urandom()});
    send_request(OP_TRIM, 32'h0, 32'h0);
    random_requests(90, 32'h2000_0000);
    drain();

    calm <= 1'b1;
    write_budget(40'd5000);
    send_request(OP_TRIM, 32'h0, 32'h0);
    random_requests(80, 32'd1500);
    drain();

    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
`default_nettype wire
